@@ rtl/core/vfbb_pkg.sv @@
// Shared types, constants and arithmetic helpers for the view footprint box.
package vfbb_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int XW           = 34;
    localparam int ZW           = 34;
    localparam int PW           = 68;
    localparam int LAT_CORDIC   = CORDIC_STEPS + 2;
    localparam int LAT_FOOT     = 6;
    localparam int LAT_TOTAL    = LAT_CORDIC + LAT_FOOT;

    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

    localparam logic [23:0] MARGIN_RST = 24'd5120;
    localparam logic [23:0] HHALF_RST  = 24'd6400;
    localparam logic [16:0] TANH_RST   = 17'd37837;
    localparam logic [16:0] TANV_RST   = 17'd37837;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MARGIN = 2'd0;
    localparam logic [1:0] REG_HHALF  = 2'd1;
    localparam logic [1:0] REG_TANH   = 2'd2;
    localparam logic [1:0] REG_TANV   = 2'd3;

    typedef struct packed {
        logic [23:0] margin;
        logic [23:0] hhalf;
        logic [16:0] tan_h;
        logic [16:0] tan_v;
    } t_cfg;

    typedef struct packed {
        logic signed [39:0] cx;
        logic signed [39:0] cy;
        logic signed [39:0] cz;
        logic [23:0]        depth;
    } t_side;

    // Arctangent of 2^-i in 1/2^32 turn
    function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
        logic [29:0] a;
        case (i)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10679838;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            5'd24: a = 30'd41;
            5'd25: a = 30'd20;
            5'd26: a = 30'd10;
            5'd27: a = 30'd5;
            default: a = 30'd0;
        endcase
        return signed'(ZW'(a));
    endfunction

    // Round a Q.30-scaled product to nearest, ties upward
    function automatic logic signed [37:0] rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + PW'(64'sd536870912)) >>> 30;
        return s[37:0];
    endfunction

    // Clamp to the 40-bit signed coordinate range
    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        if (v > 42'sd549755813887) begin
            return 40'sh7FFFFFFFFF;
        end else if (v < -42'sd549755813888) begin
            return 40'sh8000000000;
        end
        return v[39:0];
    endfunction

endpackage

@@ rtl/core/view_footprint_bounding_box_unit.sv @@
// Top level of the view footprint box: config registers, three CORDICs, footprint pipe.
// Throughput: one pose per cycle; the 28-step CORDIC pipes and the footprint stages
// all advance every cycle, so busy stays low.
// Each result beat is on the outputs for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the valid bits and loads register defaults.
module view_footprint_bounding_box_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [39:0] i_cam_x,
    input  logic signed [39:0] i_cam_y,
    input  logic signed [39:0] i_cam_z,
    input  logic [15:0]        i_azimuth_angle,
    input  logic [15:0]        i_roll_angle,
    input  logic [15:0]        i_pitch_angle,
    input  logic [23:0]        i_view_depth,
    output logic               o_valid,
    output logic signed [39:0] o_world_x_min,
    output logic signed [39:0] o_world_x_max,
    output logic signed [39:0] o_world_y_min,
    output logic signed [39:0] o_world_y_max,
    output logic signed [39:0] o_world_z_min,
    output logic signed [39:0] o_world_z_max,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vfbb_pkg::*;

    t_cfg r_cfg;
    logic wr_en;
    logic accept;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.margin <= MARGIN_RST;
            r_cfg.hhalf  <= HHALF_RST;
            r_cfg.tan_h  <= TANH_RST;
            r_cfg.tan_v  <= TANV_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_MARGIN: r_cfg.margin <= pwdata[23:0];
                REG_HHALF:  r_cfg.hhalf  <= pwdata[23:0];
                REG_TANH:   r_cfg.tan_h  <= pwdata[16:0];
                REG_TANV:   r_cfg.tan_v  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_MARGIN: prdata = 32'(r_cfg.margin);
            REG_HHALF:  prdata = 32'(r_cfg.hhalf);
            REG_TANH:   prdata = 32'(r_cfg.tan_h);
            REG_TANV:   prdata = 32'(r_cfg.tan_v);
            default:    prdata = '0;
        endcase
    end

    // Delay position and depth to meet the CORDIC outputs
    t_side r_sd [0:LAT_CORDIC-1];
    t_side in_side;

    assign in_side = '{cx: i_cam_x, cy: i_cam_y, cz: i_cam_z, depth: i_view_depth};

    always_ff @(posedge i_clk) begin
        r_sd[0] <= in_side;
        for (int k = 1; k < LAT_CORDIC; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    logic v_az, v_roll, v_pitch;
    logic signed [XW-1:0] cz, sz, cy, sy, cx, sx;

    vfbb_cordic u_cordic_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_angle (i_azimuth_angle),
        .o_valid (v_az),
        .o_cos   (cz),
        .o_sin   (sz)
    );

    vfbb_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_angle (i_roll_angle),
        .o_valid (v_roll),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    vfbb_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_angle (i_pitch_angle),
        .o_valid (v_pitch),
        .o_cos   (cx),
        .o_sin   (sx)
    );

    vfbb_footprint u_footprint (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (v_az & v_roll & v_pitch),
        .i_cfg         (r_cfg),
        .i_side        (r_sd[LAT_CORDIC-1]),
        .i_cz          (cz),
        .i_sz          (sz),
        .i_cy          (cy),
        .i_sy          (sy),
        .i_cx          (cx),
        .i_sx          (sx),
        .o_valid       (o_valid),
        .o_world_x_min (o_world_x_min),
        .o_world_x_max (o_world_x_max),
        .o_world_y_min (o_world_y_min),
        .o_world_y_max (o_world_y_max),
        .o_world_z_min (o_world_z_min),
        .o_world_z_max (o_world_z_max)
    );

endmodule

@@ rtl/core/vfbb_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cosine and sine of a 16-bit turn angle.
module vfbb_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [15:0]                   i_angle,
    output logic                          o_valid,
    output logic signed [vfbb_pkg::XW-1:0] o_cos,
    output logic signed [vfbb_pkg::XW-1:0] o_sin
);
    import vfbb_pkg::*;

    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd2147483648);

    logic signed [XW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS];
    logic                 r_neg [0:CORDIC_STEPS];
    logic                 r_v [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_cos, r_sin;
    logic                 r_ov;

    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] n_z0;
    logic                 n_neg0;

    // Fold the angle into the right half plane
    always_comb begin
        z_in   = {{(ZW-32){i_angle[15]}}, i_angle, 16'h0000};
        n_z0   = z_in;
        n_neg0 = 1'b0;
        if (z_in > QUARTER) begin
            n_z0   = z_in - HALF;
            n_neg0 = 1'b1;
        end else if (z_in < -QUARTER) begin
            n_z0   = z_in + HALF;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0]   <= CORDIC_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= n_z0;
        r_neg[0] <= n_neg0;
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            if (!r_z[k][ZW-1]) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - atan_step(5'(k));
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + atan_step(5'(k));
            end
            r_neg[k+1] <= r_neg[k];
        end
    end

    // Undo the half-turn fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[CORDIC_STEPS];
        end
        r_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        r_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
    end

    assign o_valid = r_ov;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

@@ rtl/core/vfbb_footprint.sv @@
// Rotation matrix, corner rotation, extremes and saturation, six register stages.
module vfbb_footprint (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  vfbb_pkg::t_cfg                 i_cfg,
    input  vfbb_pkg::t_side                i_side,
    input  logic signed [vfbb_pkg::XW-1:0] i_cz,
    input  logic signed [vfbb_pkg::XW-1:0] i_sz,
    input  logic signed [vfbb_pkg::XW-1:0] i_cy,
    input  logic signed [vfbb_pkg::XW-1:0] i_sy,
    input  logic signed [vfbb_pkg::XW-1:0] i_cx,
    input  logic signed [vfbb_pkg::XW-1:0] i_sx,
    output logic                           o_valid,
    output logic signed [39:0]             o_world_x_min,
    output logic signed [39:0]             o_world_x_max,
    output logic signed [39:0]             o_world_y_min,
    output logic signed [39:0]             o_world_y_max,
    output logic signed [39:0]             o_world_z_min,
    output logic signed [39:0]             o_world_z_max
);
    import vfbb_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_side r_s1, r_s2, r_s3, r_s4, r_s5;

    // Stage 1: first matrix products and depth terms
    logic signed [PW-1:0] p_r0, p_r1, p_t, p_a, p_b;
    logic [40:0]          dh_prod, dv_prod;
    logic [40:0]          dh_rnd, dv_rnd;
    logic signed [XW-1:0] r_r0, r_r1, r_t, r_a, r_b, r_czs, r_szs;
    logic [25:0]          r_w1, r_h1;

    assign p_r0    = i_cz * i_cy;
    assign p_r1    = i_sz * i_cy;
    assign p_t     = i_sy * i_sx;
    assign p_a     = i_sz * i_cx;
    assign p_b     = i_cz * i_cx;
    assign dh_prod = 41'(i_side.depth) * 41'(i_cfg.tan_h);
    assign dv_prod = 41'(i_side.depth) * 41'(i_cfg.tan_v);
    assign dh_rnd  = (dh_prod + 41'd32768) >> 16;
    assign dv_rnd  = (dv_prod + 41'd32768) >> 16;

    always_ff @(posedge i_clk) begin
        r_r0  <= XW'(rnd30(p_r0));
        r_r1  <= XW'(rnd30(p_r1));
        r_t   <= XW'(rnd30(p_t));
        r_a   <= XW'(rnd30(p_a));
        r_b   <= XW'(rnd30(p_b));
        r_czs <= i_cz;
        r_szs <= i_sz;
        r_w1  <= 26'(i_cfg.margin) + dh_rnd[25:0];
        r_h1  <= 26'(i_cfg.hhalf) + dv_rnd[25:0];
        r_s1  <= i_side;
    end

    // Stage 2: second products, finish R3 and R4
    logic signed [PW-1:0] p_c, p_e;
    logic signed [37:0]   c_rnd, e_rnd;
    logic signed [XW:0]   r_r3, r_r4;
    logic signed [XW-1:0] r_r0b, r_r1b;
    logic [25:0]          r_w2, r_h2;

    assign p_c   = r_czs * r_t;
    assign p_e   = r_szs * r_t;
    assign c_rnd = rnd30(p_c);
    assign e_rnd = rnd30(p_e);

    always_ff @(posedge i_clk) begin
        r_r3  <= (XW+1)'(c_rnd) - (XW+1)'(r_a);
        r_r4  <= (XW+1)'(e_rnd) + (XW+1)'(r_b);
        r_r0b <= r_r0;
        r_r1b <= r_r1;
        r_w2  <= r_w1;
        r_h2  <= r_h1;
        r_s2  <= r_s1;
    end

    // Stage 3: corner products
    logic signed [24:0] m_s, d_s;
    logic signed [26:0] w_s;
    logic signed [63:0] p_mr0, p_mr1, p_wr0, p_wr1, p_dr3, p_dr4;
    logic signed [63:0] r_mr0, r_mr1, r_wr0, r_wr1, r_dr3, r_dr4;
    logic [25:0]        r_h3;

    assign m_s   = signed'({1'b0, i_cfg.margin});
    assign d_s   = signed'({1'b0, r_s2.depth});
    assign w_s   = signed'({1'b0, r_w2});
    assign p_mr0 = m_s * r_r0b;
    assign p_mr1 = m_s * r_r1b;
    assign p_wr0 = w_s * r_r0b;
    assign p_wr1 = w_s * r_r1b;
    assign p_dr3 = d_s * r_r3;
    assign p_dr4 = d_s * r_r4;

    always_ff @(posedge i_clk) begin
        r_mr0 <= p_mr0;
        r_mr1 <= p_mr1;
        r_wr0 <= p_wr0;
        r_wr1 <= p_wr1;
        r_dr3 <= p_dr3;
        r_dr4 <= p_dr4;
        r_h3  <= r_h2;
        r_s3  <= r_s2;
    end

    // Stage 4: rotated corners
    logic signed [63:0] r_px [0:3];
    logic signed [63:0] r_py [0:3];
    logic [25:0]        r_h4;

    always_ff @(posedge i_clk) begin
        r_px[0] <= -r_mr0;
        r_px[1] <= r_mr0;
        r_px[2] <= r_dr3 - r_wr0;
        r_px[3] <= r_dr3 + r_wr0;
        r_py[0] <= -r_mr1;
        r_py[1] <= r_mr1;
        r_py[2] <= r_dr4 - r_wr1;
        r_py[3] <= r_dr4 + r_wr1;
        r_h4    <= r_h3;
        r_s4    <= r_s3;
    end

    // Stage 5: extremes through a two-level compare tree
    logic signed [63:0] xl0, xl1, xh0, xh1, yl0, yl1, yh0, yh1;
    logic signed [63:0] r_xlo, r_xhi, r_ylo, r_yhi;
    logic [25:0]        r_h5;

    assign xl0 = (r_px[0] < r_px[1]) ? r_px[0] : r_px[1];
    assign xl1 = (r_px[2] < r_px[3]) ? r_px[2] : r_px[3];
    assign xh0 = (r_px[0] > r_px[1]) ? r_px[0] : r_px[1];
    assign xh1 = (r_px[2] > r_px[3]) ? r_px[2] : r_px[3];
    assign yl0 = (r_py[0] < r_py[1]) ? r_py[0] : r_py[1];
    assign yl1 = (r_py[2] < r_py[3]) ? r_py[2] : r_py[3];
    assign yh0 = (r_py[0] > r_py[1]) ? r_py[0] : r_py[1];
    assign yh1 = (r_py[2] > r_py[3]) ? r_py[2] : r_py[3];

    always_ff @(posedge i_clk) begin
        r_xlo <= (xl0 < xl1) ? xl0 : xl1;
        r_xhi <= (xh0 > xh1) ? xh0 : xh1;
        r_ylo <= (yl0 < yl1) ? yl0 : yl1;
        r_yhi <= (yh0 > yh1) ? yh0 : yh1;
        r_h5  <= r_h4;
        r_s5  <= r_s4;
    end

    // Stage 6: round, offset by camera, saturate
    logic signed [41:0] cx_e, cy_e, cz_e, h_e;
    logic signed [39:0] r_xmin, r_xmax, r_ymin, r_ymax, r_zmin, r_zmax;

    assign cx_e = 42'(r_s5.cx);
    assign cy_e = 42'(r_s5.cy);
    assign cz_e = 42'(r_s5.cz);
    assign h_e  = signed'({16'h0000, r_h5});

    always_ff @(posedge i_clk) begin
        r_xmin <= sat40(42'(rnd30(PW'(r_xlo))) + cx_e);
        r_xmax <= sat40(42'(rnd30(PW'(r_xhi))) + cx_e);
        r_ymin <= sat40(42'(rnd30(PW'(r_ylo))) + cy_e);
        r_ymax <= sat40(42'(rnd30(PW'(r_yhi))) + cy_e);
        r_zmin <= sat40(cz_e - h_e);
        r_zmax <= sat40(cz_e + h_e);
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign o_valid       = r_v6;
    assign o_world_x_min = r_xmin;
    assign o_world_x_max = r_xmax;
    assign o_world_y_min = r_ymin;
    assign o_world_y_max = r_ymax;
    assign o_world_z_min = r_zmin;
    assign o_world_z_max = r_zmax;

endmodule

@@ rtl/core/vfbb_checker.sv @@
// Port-level checks for the view footprint box, bound to the top level.
module vfbb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [39:0] o_world_x_min,
    input logic signed [39:0] o_world_x_max,
    input logic signed [39:0] o_world_y_min,
    input logic signed [39:0] o_world_y_max,
    input logic signed [39:0] o_world_z_min,
    input logic signed [39:0] o_world_z_max
);
    import vfbb_pkg::*;

    // Every accepted beat comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT_TOTAL o_valid)
        else $error("result missing after accepted pose");

    // No result without a pose accepted the fixed latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT_TOTAL))
        else $error("result without matching pose");

    // Box bounds are ordered
    a_x_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_world_x_min <= o_world_x_max && o_world_y_min <= o_world_y_max))
        else $error("x or y bounds out of order");

    a_z_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_world_z_min <= o_world_z_max))
        else $error("z bounds out of order");

endmodule

bind view_footprint_bounding_box_unit vfbb_checker u_vfbb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_world_x_min (o_world_x_min),
    .o_world_x_max (o_world_x_max),
    .o_world_y_min (o_world_y_min),
    .o_world_y_max (o_world_y_max),
    .o_world_z_min (o_world_z_min),
    .o_world_z_max (o_world_z_max)
);

@@ bench/tb_view_footprint_bounding_box_unit.sv @@
// Testbench for the view footprint bounding box unit: directed and random poses checked against a predictor.
`timescale 1ns / 1ps

module tb_view_footprint_bounding_box_unit;
    import vfbb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = LAT_TOTAL + 20;

    // Expected footprint of one pose
    typedef struct packed {
        logic signed [39:0] x_min, x_max, y_min, y_max, z_min, z_max;
    } t_box;

    typedef struct {
        logic signed [39:0] cx, cy, cz;
        logic [15:0]        az, rl, pt;
        logic [23:0]        depth;
    } t_pose;

    // Tracks expected boxes in order of acceptance and compares each result beat
    class box_scoreboard;
        t_box pending[$];
        int   mismatches;
        int   checked;

        function void note_pose(t_box b);
            pending.push_back(b);
        endfunction

        function void check_box(t_box act);
            t_box exp_b;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
                return;
            end
            exp_b = pending.pop_front();
            checked++;
            if (act != exp_b) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"box %0d: exp x[%0d,%0d] y[%0d,%0d] z[%0d,%0d]",
                              " got x[%0d,%0d] y[%0d,%0d] z[%0d,%0d]"},
                        checked, exp_b.x_min, exp_b.x_max, exp_b.y_min, exp_b.y_max,
                        exp_b.z_min, exp_b.z_max, act.x_min, act.x_max, act.y_min,
                        act.y_max, act.z_min, act.z_max);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n, start, busy, o_valid;
    logic signed [39:0] i_cam_x, i_cam_y, i_cam_z;
    logic [15:0]        i_azimuth_angle, i_roll_angle, i_pitch_angle;
    logic [23:0]        i_view_depth;
    logic signed [39:0] o_world_x_min, o_world_x_max, o_world_y_min, o_world_y_max;
    logic signed [39:0] o_world_z_min, o_world_z_max;
    logic               psel, penable, pwrite, pready;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;

    view_footprint_bounding_box_unit uut (.*);

    box_scoreboard sb;
    t_cfg          cfg_model;
    int            idle_cycles;
    int            poses_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Arithmetic shift right rounding toward minus infinity
    function automatic longint asr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q30(longint p);
        return (p + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [39:0] clamp40(longint v);
        if (v > 64'sd549755813887) return 40'sh7FFFFFFFFF;
        if (v < -64'sd549755813888) return 40'sh8000000000;
        return v[39:0];
    endfunction

    // Rotation-mode CORDIC on a 16-bit turn angle, Q1.30 results
    task automatic turn_sincos(input logic [15:0] ang, output longint c, output longint s);
        longint z, x, y, nx;
        longint atab[28] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
            20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
        bit flip;
        z = longint'(ang) << 16;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
        if (z > (64'sd1 << 30)) begin
            z -= (64'sd1 << 31); flip = 1;
        end else if (z < -(64'sd1 << 30)) begin
            z += (64'sd1 << 31); flip = 1;
        end
        for (int i = 0; i < 28; i++) begin
            if (z >= 0) begin
                nx = x - asr_floor(y, i); y = y + asr_floor(x, i); z -= atab[i];
            end else begin
                nx = x + asr_floor(y, i); y = y - asr_floor(x, i); z += atab[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_box(input t_pose p, output t_box b);
        longint cz_, sz_, cy_, sy_, cx_, sx_, r0, r1, r3, r4, t, w, h, d, m;
        longint px[4], py[4], lo, hi;
        turn_sincos(p.az, cz_, sz_);
        turn_sincos(p.rl, cy_, sy_);
        turn_sincos(p.pt, cx_, sx_);
        r0 = round_q30(cz_ * cy_);
        r1 = round_q30(sz_ * cy_);
        t  = round_q30(sy_ * sx_);
        r3 = round_q30(cz_ * t) - round_q30(sz_ * cx_);
        r4 = round_q30(cz_ * cx_) + round_q30(sz_ * t);
        d = longint'(p.depth);
        m = longint'(cfg_model.margin);
        w = m + ((d * longint'(cfg_model.tan_h) + 32768) >>> 16);
        h = longint'(cfg_model.hhalf) + ((d * longint'(cfg_model.tan_v) + 32768) >>> 16);
        px[0] = -m * r0;          py[0] = -m * r1;
        px[1] = m * r0;           py[1] = m * r1;
        px[2] = -w * r0 + d * r3; py[2] = -w * r1 + d * r4;
        px[3] = w * r0 + d * r3;  py[3] = w * r1 + d * r4;
        lo = px[0]; hi = px[0];
        for (int k = 1; k < 4; k++) begin
            if (px[k] < lo) lo = px[k];
            if (px[k] > hi) hi = px[k];
        end
        b.x_min = clamp40(round_q30(lo) + longint'(p.cx));
        b.x_max = clamp40(round_q30(hi) + longint'(p.cx));
        lo = py[0]; hi = py[0];
        for (int k = 1; k < 4; k++) begin
            if (py[k] < lo) lo = py[k];
            if (py[k] > hi) hi = py[k];
        end
        b.y_min = clamp40(round_q30(lo) + longint'(p.cy));
        b.y_max = clamp40(round_q30(hi) + longint'(p.cy));
        b.z_min = clamp40(longint'(p.cz) - h);
        b.z_max = clamp40(longint'(p.cz) + h);
    endtask

    // Write one register over the APB port: setup then access
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MARGIN: cfg_model.margin = val[23:0];
            REG_HHALF:  cfg_model.hhalf  = val[23:0];
            REG_TANH:   cfg_model.tan_h  = val[16:0];
            default:    cfg_model.tan_v  = val[16:0];
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] m, input logic [31:0] hh,
                                  input logic [31:0] th, input logic [31:0] tv);
        write_reg(REG_MARGIN, m);
        write_reg(REG_HHALF, hh);
        write_reg(REG_TANH, th);
        write_reg(REG_TANV, tv);
    endtask

    // Hold start for one beat until accepted, then keep it for the next pose or drop it for a random gap
    task automatic send_pose(input t_pose p);
        t_box b;
        int gap;
        start           <= 1'b1;
        i_cam_x         <= p.cx;
        i_cam_y         <= p.cy;
        i_cam_z         <= p.cz;
        i_azimuth_angle <= p.az;
        i_roll_angle    <= p.rl;
        i_pitch_angle   <= p.pt;
        i_view_depth    <= p.depth;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_box(p, b);
        sb.note_pose(b);
        poses_sent++;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [39:0] rand40();
        logic [39:0] v;
        v = 40'({$urandom(), $urandom()});
        case ($urandom_range(0, 5))
            0: v = 40'(40'sh7FFFFFFFFF - $urandom_range(0, 3));
            1: v = 40'(40'sh8000000000 + $urandom_range(0, 3));
            2, 3: v = {{16{v[39]}}, v[23:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        p.cx = rand40();
        p.cy = rand40();
        p.cz = rand40();
        p.az = 16'($urandom());
        p.rl = 16'($urandom());
        p.pt = 16'($urandom());
        p.depth = ($urandom_range(0, 7) == 0) ? 24'(24'hFFFFFF - $urandom_range(0, 3))
                                              : 24'($urandom());
        return p;
    endfunction

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_poses();
        t_pose p;
        logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                 16'hFFFF, 16'h2000, 16'h4001, 16'hBFFF};
        for (int i = 0; i < 8; i++) begin
            p = '{cx: 0, cy: 0, cz: 0, az: angs[i], rl: angs[(i + 3) % 8],
                  pt: angs[(i + 5) % 8], depth: 24'd25600};
            send_pose(p);
        end
        // Saturating corners and extreme fields
        p = '{cx: 40'sh7FFFFFFFFF, cy: 40'sh7FFFFFFFFF, cz: 40'sh7FFFFFFFFF,
              az: 16'h0000, rl: 16'h0000, pt: 16'h0000, depth: 24'hFFFFFF};
        send_pose(p);
        p = '{cx: 40'sh8000000000, cy: 40'sh8000000000, cz: 40'sh8000000000,
              az: 16'h8000, rl: 16'hFFFF, pt: 16'hFFFF, depth: 24'hFFFFFF};
        send_pose(p);
        p = '{cx: 40'sh8000000000, cy: 40'sh7FFFFFFFFF, cz: 0,
              az: 16'h4000, rl: 16'h0000, pt: 16'h8000, depth: 24'd0};
        send_pose(p);
        p = '{cx: -40'sd1, cy: 40'sd1, cz: -40'sd256,
              az: 16'h1234, rl: 16'hFEDC, pt: 16'h7FFF, depth: 24'd1};
        send_pose(p);
    endtask

    // Count result beats into the scoreboard
    always @(posedge i_clk) begin
        t_box act;
        if (i_rst_n && o_valid) begin
            act = '{o_world_x_min, o_world_x_max, o_world_y_min, o_world_y_max,
                    o_world_z_min, o_world_z_max};
            sb.check_box(act);
        end
    end

    // Watchdog on cycles with no accepted beat in either direction and no register access
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("tb_view_footprint_bounding_box_unit NOT OK");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        idle_cycles = 0;
        poses_sent = 0;
        cfg_model = '{margin: MARGIN_RST, hhalf: HHALF_RST, tan_h: TANH_RST, tan_v: TANV_RST};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cam_x = '0; i_cam_y = '0; i_cam_z = '0;
        i_azimuth_angle = '0; i_roll_angle = '0; i_pitch_angle = '0;
        i_view_depth = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults after reset
        directed_poses();
        drain_results();

        // Extreme register settings, with upper bits beyond register width
        write_all_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        directed_poses();
        drain_results();
        write_all_regs(32'd0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 40; i++) send_pose(rand_pose());
        drain_results();

        // Random settings with random poses
        for (int ph = 0; ph < 6; ph++) begin
            write_all_regs($urandom(), $urandom(), $urandom(), $urandom());
            for (int i = 0; i < 55; i++) send_pose(rand_pose());
            drain_results();
        end

        write_all_regs(32'(MARGIN_RST), 32'(HHALF_RST), 32'(TANH_RST), 32'(TANV_RST));
        for (int i = 0; i < 20; i++) send_pose(rand_pose());
        drain_results();

        $display("Sent %0d poses over ten register settings, %0d boxes checked",
                 poses_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb_view_footprint_bounding_box_unit OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb_view_footprint_bounding_box_unit NOT OK");
        end
        $finish;
    end

endmodule

@@ view_footprint_bounding_box_unit.f @@
rtl/core/vfbb_pkg.sv
rtl/core/vfbb_cordic.sv
rtl/core/vfbb_footprint.sv
rtl/core/view_footprint_bounding_box_unit.sv
rtl/core/vfbb_checker.sv
bench/tb_view_footprint_bounding_box_unit.sv
